[src/replica_pick_with_retry_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the replica picker
// Shared property shapes, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef REPLICA_PICK_WITH_RETRY_DEFINES_SVH
`define REPLICA_PICK_WITH_RETRY_DEFINES_SVH

// Same-cycle implication.
`define RPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("replica picker assertion failed");

// Next-cycle implication.
`define RPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("replica picker assertion failed");

`endif

[src/rpr_pkg.sv]
// ---------------------------------------------------------------------------
// Replica picker package
// Field layout, codes and controller types shared by the picker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rpr_pkg;

    // Stream widths.
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // Field widths.
    localparam int MODE_W    = 2;
    localparam int CLUSTER_W = 8;
    localparam int LOAD_W    = 32;
    localparam int RND_W     = 16;
    localparam int LAST_W    = 3;
    localparam int IDX_OUT_W = 3;
    localparam int OUTC_W    = 2;
    localparam int BITCNT_W  = $clog2(RND_W);

    // Input word layout, lowest bit up.
    localparam int FIRST_LSB   = 0;
    localparam int CLUSTER_LSB = 1;
    localparam int LOAD_LSB    = CLUSTER_LSB + CLUSTER_W;
    localparam int RND_LSB     = LOAD_LSB + LOAD_W;
    localparam int LAST_LSB    = RND_LSB + RND_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL   = 1'd1;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RETRY = 2'd2;

    // Result outcomes.
    localparam logic [OUTC_W-1:0] OUT_CHOSEN  = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_INVALID = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_NONE    = 2'd2;

    // Starting minimum for the least-loaded search; every 32-bit load is
    // below or equal to it, and the first entry is the default pick.
    localparam logic [LOAD_W-1:0] LOAD_START = '1;

    typedef enum logic [2:0] {
        CLS_LOAD,
        CLS_BAL,
        CLS_RND,
        CLS_RETRY,
        CLS_ERR
    } rpr_cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAL,
        ST_RND,
        ST_RETRY,
        ST_OUT
    } rpr_state_t;

    typedef struct packed {
        logic accept;
        logic bal_step;
        logic rnd_step;
        logic retry_step;
        logic commit;
    } rpr_cmd_t;

    typedef struct packed {
        rpr_cls_t cls;
        logic     scan_done;
        logic     out_free;
    } rpr_status_t;

endpackage

`default_nettype wire

[src/rpr_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module rpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/rpr_ctrl.sv]
// ---------------------------------------------------------------------------
// Replica picker controller
// Sequences accept, scan or modulo steps and the hand-off to the output.
// ---------------------------------------------------------------------------
`default_nettype none

module rpr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire rpr_pkg::rpr_status_t status,
    output rpr_pkg::rpr_cmd_t        cmd
);

    import rpr_pkg::*;

    rpr_state_t state_reg;
    rpr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (status.cls)
                        CLS_LOAD:  state_next = ST_IDLE;
                        CLS_BAL:   state_next = ST_BAL;
                        CLS_RND:   state_next = ST_RND;
                        CLS_RETRY: state_next = ST_RETRY;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_BAL, ST_RND, ST_RETRY:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        cmd.accept     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.bal_step   = (state_reg == ST_BAL);
        cmd.rnd_step   = (state_reg == ST_RND);
        cmd.retry_step = (state_reg == ST_RETRY);
        cmd.commit     = (state_reg == ST_OUT) && status.out_free;
    end

endmodule

`default_nettype wire

[src/rpr_datapath.sv]
// ---------------------------------------------------------------------------
// Replica picker datapath
// Replica table, requested flags, search and modulo units, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rpr_datapath #(
    parameter int MAX_REPLICAS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [rpr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [rpr_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [rpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rpr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire rpr_pkg::rpr_cmd_t               cmd,
    output rpr_pkg::rpr_status_t                 status,
    output logic [$clog2(MAX_REPLICAS+1)-1:0]    count,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rpr_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [rpr_pkg::M_TUSER_W-1:0]        m_tuser
);

    import rpr_pkg::*;

    localparam int IW    = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
    localparam int CW    = $clog2(MAX_REPLICAS + 1);
    localparam int CMPW  = (CW > LAST_W) ? CW : LAST_W;
    localparam int WORDW = CLUSTER_W + LOAD_W;

    // Input fields.
    logic [MODE_W-1:0]    in_mode;
    logic                 in_first;
    logic [CLUSTER_W-1:0] in_cluster;
    logic [LOAD_W-1:0]    in_load;
    logic [RND_W-1:0]     in_rnd;
    logic [LAST_W-1:0]    in_last;

    assign in_mode    = s_tuser[MODE_W-1:0];
    assign in_first   = s_tdata[FIRST_LSB];
    assign in_cluster = s_tdata[CLUSTER_LSB +: CLUSTER_W];
    assign in_load    = s_tdata[LOAD_LSB +: LOAD_W];
    assign in_rnd     = s_tdata[RND_LSB +: RND_W];
    assign in_last    = s_tdata[LAST_LSB +: LAST_W];

    // Control state.
    logic                    bal_en_reg;
    logic [CLUSTER_W-1:0]    local_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [MAX_REPLICAS-1:0] req_reg, req_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // Working registers.
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [IW-1:0]        ev_idx_reg, ev_idx_next;
    logic [LOAD_W-1:0]    best_reg, best_next;
    logic [IW-1:0]        pick_reg, pick_next;
    logic                 local0_reg, local0_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [BITCNT_W-1:0]  bitcnt_reg, bitcnt_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;
    logic [CW-1:0]        tries_reg, tries_next;
    logic [IW-1:0]        nx_reg, nx_next;
    logic [IW-1:0]        res_idx_reg, res_idx_next;
    logic [OUTC_W-1:0]    res_outc_reg, res_outc_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // Table memory.
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [WORDW-1:0] ram_wdata;
    logic [WORDW-1:0] ram_rdata;
    logic [CLUSTER_W-1:0] rd_cluster;
    logic [LOAD_W-1:0]    rd_load;

    rpr_ram #(
        .WIDTH (WORDW),
        .DEPTH (MAX_REPLICAS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (IW'(rd_idx_reg)),
        .rdata (ram_rdata)
    );

    assign rd_load    = ram_rdata[LOAD_W-1:0];
    assign rd_cluster = ram_rdata[WORDW-1:LOAD_W];

    // Item decode.
    logic [CW-1:0]   eff_count;
    logic [CMPW-1:0] last_p1;
    logic [IW-1:0]   retry_start;
    logic            last_bad;
    rpr_cls_t        cls;

    assign eff_count   = in_first ? '0 : count_reg;
    assign last_p1     = CMPW'(in_last) + CMPW'(1);
    assign retry_start = (last_p1 == CMPW'(count_reg)) ? '0 : IW'(last_p1);
    assign last_bad    = CMPW'(in_last) >= CMPW'(count_reg);

    always_comb
    begin
        unique case (in_mode)
            MODE_LOAD:  cls = CLS_LOAD;
            MODE_PICK:  cls = (count_reg == '0) ? CLS_ERR : (bal_en_reg ? CLS_BAL : CLS_RND);
            MODE_RETRY: cls = ((count_reg == '0) || last_bad) ? CLS_ERR : CLS_RETRY;
            default:    cls = CLS_ERR;
        endcase
    end

    // Least-loaded scan: one read issued and one entry evaluated per cycle.
    logic rd_ok, span_end, zero_hit, better, bal_done;

    assign rd_ok    = rd_idx_reg < count_reg;
    assign span_end = ev_valid_reg && (ev_idx_reg != '0) && local0_reg
                      && (rd_cluster != local_reg);
    assign zero_hit = ev_valid_reg && !span_end && (rd_load == '0);
    assign better   = ev_valid_reg && !span_end && (rd_load < best_reg);
    assign bal_done = span_end || zero_hit || (!ev_valid_reg && !rd_ok);

    // Remainder by restoring steps, one random bit per cycle.
    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_cmp;
    logic [CW-1:0] rem_new;
    logic          rnd_done;

    assign rem_sh   = {rem_reg, rnd_reg[RND_W-1]};
    assign rem_cmp  = {1'b0, count_reg};
    assign rem_new  = (rem_sh >= rem_cmp) ? CW'(rem_sh - rem_cmp) : CW'(rem_sh);
    assign rnd_done = (bitcnt_reg == BITCNT_W'(RND_W - 1));

    // Circular retry walk over the requested flags.
    logic          req_cur;
    logic [CW-1:0] nx_inc;
    logic [IW-1:0] nx_wrap;
    logic          retry_none;

    assign req_cur    = req_reg[nx_reg];
    assign nx_inc     = CW'(nx_reg) + CW'(1);
    assign nx_wrap    = (nx_inc == count_reg) ? '0 : IW'(nx_inc);
    assign retry_none = req_cur && ((tries_reg + CW'(1)) == count_reg);

    always_comb
    begin
        count_next    = count_reg;
        req_next      = req_reg;
        m_tvalid_next = m_tvalid_reg;
        rd_idx_next   = rd_idx_reg;
        ev_valid_next = ev_valid_reg;
        ev_idx_next   = ev_idx_reg;
        best_next     = best_reg;
        pick_next     = pick_reg;
        local0_next   = local0_reg;
        rem_next      = rem_reg;
        bitcnt_next   = bitcnt_reg;
        rnd_next      = rnd_reg;
        tries_next    = tries_reg;
        nx_next       = nx_reg;
        res_idx_next  = res_idx_reg;
        res_outc_next = res_outc_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_waddr     = IW'(eff_count);
        ram_wdata     = {in_cluster, in_load};

        if (cmd.accept)
        begin
            rd_idx_next   = '0;
            ev_valid_next = 1'b0;
            best_next     = LOAD_START;
            pick_next     = '0;
            local0_next   = 1'b0;
            rem_next      = '0;
            bitcnt_next   = '0;
            rnd_next      = in_rnd;
            tries_next    = '0;
            nx_next       = retry_start;
            res_idx_next  = '0;
            res_outc_next = OUT_INVALID;
            if (cls == CLS_LOAD)
            begin
                if (in_first)
                begin
                    req_next = '0;
                end
                if (eff_count < CW'(MAX_REPLICAS))
                begin
                    ram_we                  = 1'b1;
                    req_next[IW'(eff_count)] = 1'b0;
                    count_next              = eff_count + CW'(1);
                end
                else
                begin
                    count_next = eff_count;
                end
            end
        end

        if (cmd.bal_step)
        begin
            ev_valid_next = rd_ok;
            ev_idx_next   = IW'(rd_idx_reg);
            if (rd_ok)
            begin
                rd_idx_next = rd_idx_reg + CW'(1);
            end
            if (ev_valid_reg && (ev_idx_reg == '0))
            begin
                local0_next = (rd_cluster == local_reg);
            end
            if (better)
            begin
                best_next = rd_load;
                pick_next = ev_idx_reg;
            end
            res_idx_next  = zero_hit ? ev_idx_reg : pick_reg;
            res_outc_next = OUT_CHOSEN;
        end

        if (cmd.rnd_step)
        begin
            rem_next      = rem_new;
            bitcnt_next   = bitcnt_reg + BITCNT_W'(1);
            rnd_next      = {rnd_reg[RND_W-2:0], 1'b0};
            res_idx_next  = IW'(rem_new);
            res_outc_next = OUT_CHOSEN;
        end

        if (cmd.retry_step)
        begin
            tries_next = tries_reg + CW'(1);
            nx_next    = nx_wrap;
            if (!req_cur)
            begin
                res_idx_next  = nx_reg;
                res_outc_next = OUT_CHOSEN;
            end
            else
            begin
                res_idx_next  = '0;
                res_outc_next = OUT_NONE;
            end
        end

        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'(IDX_OUT_W'(res_idx_reg));
            m_tuser_next  = res_outc_reg;
            if (res_outc_reg == OUT_CHOSEN)
            begin
                req_next[res_idx_reg] = 1'b1;
            end
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bal_en_reg   <= 1'b0;
            local_reg    <= '0;
            count_reg    <= '0;
            req_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_BALANCE))
            begin
                bal_en_reg <= cfg_wdata[0];
            end
            if (cfg_we && (cfg_index == CFG_LOCAL))
            begin
                local_reg <= cfg_wdata[CLUSTER_W-1:0];
            end
            count_reg    <= count_next;
            req_reg      <= req_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        ev_valid_reg <= ev_valid_next;
        ev_idx_reg   <= ev_idx_next;
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        local0_reg   <= local0_next;
        rem_reg      <= rem_next;
        bitcnt_reg   <= bitcnt_next;
        rnd_reg      <= rnd_next;
        tries_reg    <= tries_next;
        nx_reg       <= nx_next;
        res_idx_reg  <= res_idx_next;
        res_outc_reg <= res_outc_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_comb
    begin
        status.cls = cls;
        status.out_free = !m_tvalid_reg || m_tready;
        priority if (cmd.bal_step)
        begin
            status.scan_done = bal_done;
        end
        else if (cmd.rnd_step)
        begin
            status.scan_done = rnd_done;
        end
        else if (cmd.retry_step)
        begin
            status.scan_done = !req_cur || retry_none;
        end
        else
        begin
            status.scan_done = 1'b0;
        end
    end

    assign count    = count_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[src/replica_pick_with_retry.sv]
// A word passes through its search steps and then the output state, where its result is
// written to the result word register. An invalid word takes no search step, a retry
// walks the requested flags, a balanced first pick scans the table and a random first
// pick takes one step per random bit. A load word leaves the input free for the next word;
// any other holds it until its result is written, which waits for the previous result word.
// Reset clears the count, requested flags, registers and handshakes; table data is kept.
// ---------------------------------------------------------------------------
// Replica picker with retry
// Least-loaded or random first pick over a small replica table, with a
// circular retry that skips replicas already requested.
// ---------------------------------------------------------------------------
`default_nettype none
`include "replica_pick_with_retry_defines.svh"

module replica_pick_with_retry #(
    parameter int MAX_REPLICAS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input words.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata, lowest bit up: first_entry[0], entry_cluster[8:1], entry_load[40:9],
    // random_value[56:41], last_index[59:57], zero fill [63:60].
    input  wire logic [rpr_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: mode[1:0].
    input  wire logic [rpr_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result words.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata, lowest bit up: chosen_index[2:0], zero fill [7:3].
    output logic [rpr_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: outcome[1:0].
    output logic [rpr_pkg::M_TUSER_W-1:0]        m_tuser,
    // Configuration writes: index 0 balance_enable, index 1 local_cluster.
    input  wire logic                            cfg_we,
    input  wire logic [rpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rpr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import rpr_pkg::*;

    localparam int CW = $clog2(MAX_REPLICAS + 1);

    // The controller only sequences; every table access and comparison
    // lives in the datapath, and the two talk through cmd and status.
    rpr_cmd_t      cmd;
    rpr_status_t   status;
    logic [CW-1:0] count;

    rpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the table, the requested flags, the search and
    // modulo registers, and the result register that lets the next word
    // be accepted while a result still waits downstream.
    rpr_datapath #(
        .MAX_REPLICAS (MAX_REPLICAS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .count     (count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A load word never produces a result.
    `RPR_ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && (s_tuser == MODE_LOAD), !$rose(m_tvalid))
    // A failed pick always reports index zero.
    `RPR_ASSERT_IMP(a_fail_idx_zero, m_tvalid && (m_tuser != OUT_CHOSEN), m_tdata == '0)
    // The table fill never passes its depth.
    `RPR_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(MAX_REPLICAS))

endmodule

`default_nettype wire

[dv/tb_replica_pick_with_retry.sv]
// ---------------------------------------------------------------------------
// Testbench for the replica picker with retry
// Drives load, first-pick, retry and unused-mode words into the picker through its input
// stream, predicts every result word with a model of the replica table, and
// compares each result field by field. A directed table comes first, then
// random request sequences under several register settings, with random
// idle cycles on both streams.
// ---------------------------------------------------------------------------
module tb_replica_pick_with_retry;

    import rpr_pkg::*;

    // The picker is built with an eight-entry table and the model matches it.
    localparam int TABLE_DEPTH = 8;

    // Mode 3 has no meaning in the picker; it must answer invalid-argument.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Random part: one register setting per phase, about 2000 words overall.
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 200;

    // Quiet time after the last result, enough for any load word still in flight to settle.
    localparam int SETTLE_CYCLES = 40;

    // Longest legal stretch without a handshake is well under the watchdog limit.
    localparam int WATCHDOG_LIMIT = 2000;

    // One input word as the picker sees it.
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic                 first_entry;
        logic [CLUSTER_W-1:0] cluster;
        logic [LOAD_W-1:0]    load;
        logic [RND_W-1:0]     rnd;
        logic [LAST_W-1:0]    last_index;
    } pick_word_t;

    // One result word.
    typedef struct packed {
        logic [IDX_OUT_W-1:0] chosen_index;
        logic [OUTC_W-1:0]    outcome;
    } pick_result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    // A row of the directed table is either an input word or a register
    // write. A word row may carry a hand-written result; otherwise the model
    // supplies it.
    typedef struct packed {
        row_kind_t             kind;
        pick_word_t            word;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] reg_value;
        logic                  typed;
        pick_result_t          result;
    } stim_row_t;

    localparam int DIR_ROWS = 27;

    logic clk = 1'b0;
    logic rst_n;

    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Model of the replica table and of the two registers.
    logic [CLUSTER_W-1:0] tbl_cluster   [TABLE_DEPTH];
    logic [LOAD_W-1:0]    tbl_load      [TABLE_DEPTH];
    logic                 tbl_requested [TABLE_DEPTH];
    int unsigned          tbl_count;
    logic                 set_balance;
    logic [CLUSTER_W-1:0] set_local;

    // Results the picker still owes, oldest first.
    pick_result_t expected_picks [$];

    stim_row_t dir_table [DIR_ROWS];

    logic [IDX_OUT_W-1:0] last_chosen;
    logic                 quiet_phase;
    int                   mismatches;
    int                   words_sent;
    int                   results_checked;
    int                   n_chosen;
    int                   n_invalid;
    int                   n_exhausted;
    int                   quiet_cycles;

    replica_pick_with_retry #(
        .MAX_REPLICAS(TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle cycles before a word on either stream. Some phases run with no
    // idling at all so that back-to-back words are seen too.
    function automatic int draw_gap();
        if (quiet_phase)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic pick_word_t rand_word();
        pick_word_t w;
        w.mode        = 2'($urandom_range(0, 3));
        w.first_entry = 1'($urandom_range(0, 1));
        w.cluster     = 8'($urandom_range(0, 255));
        w.load        = $urandom;
        w.rnd         = 16'($urandom_range(0, 65535));
        w.last_index  = 3'($urandom_range(0, 7));
        return w;
    endfunction

    // Applies one accepted word to the table model. Returns 1 when the word
    // produces a result, which is then placed in res.
    function automatic logic predict_pick(input pick_word_t w, output pick_result_t res);
        int unsigned span;
        int unsigned pick;
        int unsigned nxt;
        int unsigned i;
        logic [63:0] best;
        res.chosen_index = '0;
        res.outcome      = OUT_INVALID;
        case (w.mode)
            MODE_LOAD:
            begin
                // Starting a new table clears the requested flags and the count,
                // so the entry is kept even when the old table was full.
                if (w.first_entry)
                begin
                    for (i = 0; i < TABLE_DEPTH; i++)
                        tbl_requested[i] = 1'b0;
                    tbl_count = 0;
                end
                if (tbl_count < TABLE_DEPTH)
                begin
                    tbl_cluster[tbl_count]   = w.cluster;
                    tbl_load[tbl_count]      = w.load;
                    tbl_requested[tbl_count] = 1'b0;
                    tbl_count++;
                end
                return 1'b0;
            end
            MODE_PICK:
            begin
                if (tbl_count == 0)
                    return 1'b1;
                if (set_balance)
                begin
                    // A local first entry limits the search to the leading
                    // run of local entries.
                    span = tbl_count;
                    if (tbl_cluster[0] == set_local)
                    begin
                        span = 0;
                        while (span < tbl_count && tbl_cluster[span] == set_local)
                            span++;
                    end
                    best = 64'h7FFF_FFFF_FFFF_FFFF;
                    pick = 0;
                    for (i = 0; i < span; i++)
                    begin
                        if (tbl_load[i] == '0)
                        begin
                            pick = i;
                            break;
                        end
                        if ({32'd0, tbl_load[i]} < best)
                        begin
                            best = {32'd0, tbl_load[i]};
                            pick = i;
                        end
                    end
                end
                else
                begin
                    pick = w.rnd % tbl_count;
                end
                tbl_requested[pick] = 1'b1;
                res.chosen_index    = pick[IDX_OUT_W-1:0];
                res.outcome         = OUT_CHOSEN;
                return 1'b1;
            end
            MODE_RETRY:
            begin
                if (tbl_count == 0 || w.last_index >= tbl_count)
                    return 1'b1;
                for (i = 1; i <= tbl_count; i++)
                begin
                    nxt = (w.last_index + i) % tbl_count;
                    if (!tbl_requested[nxt])
                    begin
                        tbl_requested[nxt] = 1'b1;
                        res.chosen_index   = nxt[IDX_OUT_W-1:0];
                        res.outcome        = OUT_CHOSEN;
                        return 1'b1;
                    end
                end
                res.outcome = OUT_NONE;
                return 1'b1;
            end
            default:
            begin
                return 1'b1;
            end
        endcase
    endfunction

    // Presents one word after a random gap and waits for the handshake. The
    // valid line stays high when the next word follows with no gap, so it is
    // never lowered and raised within one time step.
    task automatic send_word(input pick_word_t w, input logic typed,
                             input pick_result_t typed_res);
        int gap;
        logic [S_TDATA_W-1:0] data;
        pick_result_t res;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        data = '0;
        data[FIRST_LSB]              = w.first_entry;
        data[CLUSTER_LSB +: CLUSTER_W] = w.cluster;
        data[LOAD_LSB +: LOAD_W]     = w.load;
        data[RND_LSB +: RND_W]       = w.rnd;
        data[LAST_LSB +: LAST_W]     = w.last_index;
        s_tdata  = data;
        s_tuser  = w.mode;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (predict_pick(w, res))
        begin
            if (typed)
                res = typed_res;
            expected_picks.push_back(res);
            last_chosen = res.chosen_index;
            case (res.outcome)
                OUT_CHOSEN:  n_chosen++;
                OUT_INVALID: n_invalid++;
                default:     n_exhausted++;
            endcase
        end
        @(negedge clk);
    endtask

    // Brings the picker to rest: input stream idle, every result collected,
    // and enough further cycles for a trailing load word to finish.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (expected_picks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (sel == CFG_BALANCE)
            set_balance = value[0];
        else
            set_local = value;
    endtask

    // A well-formed request: build a table, take a first pick, then retry a
    // few times, mostly from the index that was just chosen.
    task automatic run_request_sequence();
        pick_word_t w;
        int n_loads;
        int n_retries;
        int k;
        // Now and then more loads than the table holds, to hit the drop case.
        if ($urandom_range(0, 7) == 0)
            n_loads = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 3);
        else
            n_loads = $urandom_range(1, TABLE_DEPTH);
        for (k = 0; k < n_loads; k++)
        begin
            w = rand_word();
            w.mode = MODE_LOAD;
            if (k == 0)
                w.first_entry = ($urandom_range(0, 9) != 0);
            else
                w.first_entry = ($urandom_range(0, 15) == 0);
            // Favor the local cluster so that leading local runs of every
            // length show up; a near miss differs from it in one bit.
            case ($urandom_range(0, 3))
                0, 1:    w.cluster = set_local;
                2:       w.cluster = set_local ^ 8'(1 << $urandom_range(0, 7));
                default: w.cluster = 8'($urandom_range(0, 255));
            endcase
            // Small loads give ties; zero loads take the early exit.
            case ($urandom_range(0, 5))
                0:       w.load = '0;
                1:       w.load = '1;
                2, 3:    w.load = 32'($urandom_range(1, 3));
                default: w.load = $urandom;
            endcase
            send_word(w, 1'b0, '0);
        end
        w = rand_word();
        w.mode = MODE_PICK;
        send_word(w, 1'b0, '0);
        n_retries = $urandom_range(0, 9);
        for (k = 0; k < n_retries; k++)
        begin
            w = rand_word();
            w.mode = ($urandom_range(0, 7) == 0) ? MODE_PICK : MODE_RETRY;
            if ($urandom_range(0, 9) != 0)
                w.last_index = last_chosen;
            send_word(w, 1'b0, '0);
        end
    endtask

    // Result side: random back-pressure before every result word, and a
    // field-by-field comparison against the oldest expectation.
    initial
    begin : result_sink
        pick_result_t want;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            results_checked++;
            if (expected_picks.size() == 0)
            begin
                $error("result word with nothing expected: chosen_index %0d, outcome %0d",
                       m_tdata[IDX_OUT_W-1:0], m_tuser[OUTC_W-1:0]);
                mismatches++;
            end
            else
            begin
                want = expected_picks.pop_front();
                if (m_tdata[IDX_OUT_W-1:0] !== want.chosen_index)
                begin
                    $error("chosen_index: expected %0d, actual %0d",
                           want.chosen_index, m_tdata[IDX_OUT_W-1:0]);
                    mismatches++;
                end
                if (m_tuser[OUTC_W-1:0] !== want.outcome)
                begin
                    $error("outcome: expected %0d, actual %0d",
                           want.outcome, m_tuser[OUTC_W-1:0]);
                    mismatches++;
                end
            end
            @(negedge clk);
        end
    end

    // Ends the run if neither stream moves a word for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no word moved on either stream for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int row;
        int phase;
        int phase_start;
        int n_noise;
        int k;
        logic bal;
        logic [CFG_DATA_W-1:0] loc;
        logic [CFG_DATA_W-1:0] reg_val;
        stim_row_t r;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        quiet_phase = 1'b0;
        last_chosen = '0;
        mismatches      = 0;
        words_sent      = 0;
        results_checked = 0;
        n_chosen        = 0;
        n_invalid       = 0;
        n_exhausted     = 0;

        // Model after reset: empty table, both registers zero.
        for (k = 0; k < TABLE_DEPTH; k++)
            tbl_requested[k] = 1'b0;
        tbl_count   = 0;
        set_balance = 1'b0;
        set_local   = '0;

        // Directed part. It starts from the reset settings (random first
        // pick, local cluster 0) and switches to least-loaded halfway.
        // Columns: kind, {mode, first, cluster, load, random, last},
        //          register, value, hand-written, {index, outcome}.
        dir_table = '{
            // Pick and retry on an empty table, and the meaningless mode
            // with every field at its top value.
            '{ROW_WORD, '{MODE_PICK,   1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b1, '{3'd0, OUT_INVALID}},
            '{ROW_WORD, '{MODE_RETRY,  1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b1, '{3'd0, OUT_INVALID}},
            '{ROW_WORD, '{MODE_UNUSED, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd7},
              CFG_BALANCE, 8'h00, 1'b1, '{3'd0, OUT_INVALID}},
            // Three entries: two local ones, then a remote one with no load.
            '{ROW_WORD, '{MODE_LOAD,   1'b1, 8'h00, 32'hFFFF_FFFF, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'h00, 32'h0000_0007, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'hFF, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            // Random pick with the largest random value.
            '{ROW_WORD, '{MODE_PICK,   1'b0, 8'h00, 32'h0000_0000, 16'hFFFF, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            // Retry from an index past the end of the table.
            '{ROW_WORD, '{MODE_RETRY,  1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd7},
              CFG_BALANCE, 8'h00, 1'b1, '{3'd0, OUT_INVALID}},
            // Retries until every entry is requested, and one more.
            '{ROW_WORD, '{MODE_RETRY,  1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_RETRY,  1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd1},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_RETRY,  1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd2},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            // Least-loaded over the leading local run only.
            '{ROW_REG,  '{MODE_LOAD,   1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h01, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_PICK,   1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            // Entry 0 no longer local: the whole table is searched.
            '{ROW_REG,  '{MODE_LOAD,   1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_LOCAL,   8'hFF, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_PICK,   1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            // Fill the table to the top, with ties inside the local run.
            '{ROW_WORD, '{MODE_LOAD,   1'b1, 8'hFF, 32'h0000_0005, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'hFF, 32'h0000_0003, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'hFF, 32'h0000_0003, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'hFF, 32'h0000_0001, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'h00, 32'hFFFF_FFFF, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'h55, 32'h0000_0002, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'hAA, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            // A ninth entry is dropped.
            '{ROW_WORD, '{MODE_LOAD,   1'b0, 8'h00, 32'h0000_0001, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            '{ROW_WORD, '{MODE_PICK,   1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            // Retry from the last index wraps around to entry 0.
            '{ROW_WORD, '{MODE_RETRY,  1'b0, 8'h00, 32'h0000_0000, 16'h0000, 3'd7},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}},
            // Starting a new table while the old one is full.
            '{ROW_WORD, '{MODE_LOAD,   1'b1, 8'h00, 32'h0000_0009, 16'h0000, 3'd0},
              CFG_BALANCE, 8'h00, 1'b0, '{3'd0, OUT_CHOSEN}}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (row = 0; row < DIR_ROWS; row++)
        begin
            r = dir_table[row];
            if (r.kind == ROW_REG)
            begin
                wait_idle();
                write_reg(r.reg_sel, r.reg_value);
            end
            else
            begin
                send_word(r.word, r.typed, r.result);
            end
        end

        // Random part. The first four phases pin the registers at their
        // extremes; the rest draw them at random. The upper bits of the
        // balance write are noise that the picker must ignore.
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       begin bal = 1'b1; loc = 8'h00; end
                1:       begin bal = 1'b1; loc = 8'hFF; end
                2:       begin bal = 1'b0; loc = 8'h00; end
                3:       begin bal = 1'b0; loc = 8'hFF; end
                default: begin bal = 1'($urandom_range(0, 1)); loc = 8'($urandom_range(0, 255)); end
            endcase
            reg_val    = 8'($urandom_range(0, 255));
            reg_val[0] = bal;
            write_reg(CFG_BALANCE, reg_val);
            write_reg(CFG_LOCAL, loc);
            quiet_phase = ($urandom_range(0, 3) == 0);
            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    run_request_sequence();
                end
                else
                begin
                    // Noise: any mode, any index, any table state.
                    n_noise = $urandom_range(1, 4);
                    for (k = 0; k < n_noise; k++)
                        send_word(rand_word(), 1'b0, '0);
                end
            end
        end

        quiet_phase = 1'b0;
        wait_idle();
        if (expected_picks.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_picks.size());
            mismatches++;
        end

        $display("Run covered %0d input words and %0d result words (%0d chosen, %0d invalid, %0d exhausted).",
                 words_sent, results_checked, n_chosen, n_invalid, n_exhausted);
        $display("Register settings: directed pair plus %0d random phases, extremes included.",
                 PHASES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[replica_pick_with_retry.f]
+incdir+src
src/rpr_pkg.sv
src/rpr_ram.sv
src/rpr_ctrl.sv
src/rpr_datapath.sv
src/replica_pick_with_retry.sv
dv/tb_replica_pick_with_retry.sv
